// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the checker files of this block.
// Each macro takes a label, the clock, a property expression and a message
// string; ASSERT_PROP also takes the active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is disabled while reset is asserted.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/ovmv_pkg.sv -----
// ----------------------------------------------------------------------------
// ovmv_pkg
// Shared constants for the oversampled write latch with per-line majority
// vote: field widths, default parameters and tuser bit positions.
// ----------------------------------------------------------------------------
package ovmv_pkg;

  // Default parameter values.
  localparam int unsigned DATA_WIDTH_DEF    = 8;
  localparam int unsigned HISTORY_DEPTH_DEF = 32;

  // Fixed field widths.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned USER_W = 2;
  localparam int unsigned CNT_W  = 6;

  // Sample count saturation value and the reset value of min_samples.
  localparam logic [CNT_W-1:0] COUNT_MAX       = 6'd32;
  localparam logic [CNT_W-1:0] MIN_SAMPLES_RST = 6'd5;

  // Bit positions inside the slave-side tuser.
  localparam int unsigned USER_CLK_BIT = 0;
  localparam int unsigned USER_WR_BIT  = 1;

endpackage

// ----- rtl/core/oversampled_write_majority_vote_top.sv -----
// Output: a beat with a strobe low that closes a write cycle puts its byte into
// the output register, or into the skid register while the output is stalled.
// Throughput: one beat per cycle; the slave side stalls only while both the
// output register and the skid register hold bytes.
// Reset: asynchronous, active low; histories and count clear, min_samples = 5.
// ----------------------------------------------------------------------------
// oversampled_write_majority_vote_top
// Oversampled bus write latch. Strobe-high beats shift each data line into
// its own sample history; a strobe-low beat closes the cycle and, when enough
// samples were seen, emits the per-line majority-voted byte.
// ----------------------------------------------------------------------------
module oversampled_write_majority_vote_top #(
  parameter int unsigned DATA_WIDTH    = ovmv_pkg::DATA_WIDTH_DEF,
  parameter int unsigned HISTORY_DEPTH = ovmv_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel (min_samples).
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ovmv_pkg::CNT_W-1:0]    cfg_data_i,
  // Slave side: one sampling tick per beat.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ovmv_pkg::BYTE_W-1:0]   s_axis_tdata,  // [7:0] data_levels
  input  logic [ovmv_pkg::USER_W-1:0]   s_axis_tuser,  // [0] clock_level, [1] write_level
  // Master side: voted bytes.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ovmv_pkg::BYTE_W-1:0]   m_axis_tdata   // [7:0] data_byte
);

  localparam int unsigned OnesW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [ovmv_pkg::CNT_W-1:0] HistDepthC = ovmv_pkg::CNT_W'(HISTORY_DEPTH);

  logic                          s_accept;
  logic                          sample_tick;
  logic                          produce;
  logic                          m_pop;

  logic [ovmv_pkg::CNT_W-1:0]    min_samples_q;
  logic [ovmv_pkg::CNT_W-1:0]    count_q, count_d;
  logic [HISTORY_DEPTH-1:0]      hist_q [DATA_WIDTH];
  logic [HISTORY_DEPTH-1:0]      hist_d [DATA_WIDTH];
  logic [OnesW-1:0]              ones_q [DATA_WIDTH];
  logic [OnesW-1:0]              ones_d [DATA_WIDTH];

  logic [ovmv_pkg::CNT_W-1:0]    span;
  logic [ovmv_pkg::CNT_W-1:0]    limit;
  logic [ovmv_pkg::BYTE_W-1:0]   vote_byte;

  logic                          out_valid_q;
  logic [ovmv_pkg::BYTE_W-1:0]   out_data_q;
  logic                          skid_valid_q;
  logic [ovmv_pkg::BYTE_W-1:0]   skid_data_q;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = ~skid_valid_q;
  assign s_accept      = s_axis_tvalid & s_axis_tready;
  assign m_pop         = out_valid_q & m_axis_tready;
  assign sample_tick   = s_axis_tuser[ovmv_pkg::USER_CLK_BIT] &
                         s_axis_tuser[ovmv_pkg::USER_WR_BIT];

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_samples_q <= ovmv_pkg::MIN_SAMPLES_RST;
    end else if (cfg_valid_i) begin
      min_samples_q <= cfg_data_i;
    end
  end

  // Voting: a line is one when its ones count beats half the usable span.
  always_comb begin
    span      = (count_q > HistDepthC) ? HistDepthC : count_q;
    limit     = span >> 1;
    vote_byte = '0;
    for (int i = 0; i < DATA_WIDTH; i++) begin
      vote_byte[i] = (ovmv_pkg::CNT_W'(ones_q[i]) > limit);
    end
  end

  assign produce = s_accept & ~sample_tick & (count_q >= min_samples_q);

  // History, running ones counts and sample count. The ones count tracks
  // the bit shifted in and the bit that falls off the end of the history.
  always_comb begin
    count_d = count_q;
    for (int i = 0; i < DATA_WIDTH; i++) begin
      hist_d[i] = hist_q[i];
      ones_d[i] = ones_q[i];
    end
    if (s_accept) begin
      if (sample_tick) begin
        count_d = (count_q == ovmv_pkg::COUNT_MAX) ? count_q : count_q + 1'b1;
        for (int i = 0; i < DATA_WIDTH; i++) begin
          hist_d[i] = {hist_q[i][HISTORY_DEPTH-2:0], s_axis_tdata[i]};
          ones_d[i] = ones_q[i] + OnesW'(s_axis_tdata[i])
                      - OnesW'(hist_q[i][HISTORY_DEPTH-1]);
        end
      end else begin
        count_d = '0;
        for (int i = 0; i < DATA_WIDTH; i++) begin
          hist_d[i] = '0;
          ones_d[i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < DATA_WIDTH; i++) begin
        hist_q[i] <= '0;
        ones_q[i] <= '0;
      end
    end else begin
      count_q <= count_d;
      for (int i = 0; i < DATA_WIDTH; i++) begin
        hist_q[i] <= hist_d[i];
        ones_q[i] <= ones_d[i];
      end
    end
  end

  // Output register with a skid stage behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (m_pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (produce) begin
      if (!out_valid_q || m_pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (m_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (m_pop) begin
        out_data_q <= skid_data_q;
      end
    end else if (produce) begin
      if (!out_valid_q || m_pop) begin
        out_data_q <= vote_byte;
      end else begin
        skid_data_q <= vote_byte;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- rtl/core/ovmv_checker.sv -----
// ----------------------------------------------------------------------------
// ovmv_checker
// Port-level checks for the oversampled write latch, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ovmv_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [ovmv_pkg::USER_W-1:0] s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [ovmv_pkg::BYTE_W-1:0] m_axis_tdata
);

  logic sample_beat;

  assign sample_beat = s_axis_tvalid & s_axis_tready &
                       s_axis_tuser[ovmv_pkg::USER_CLK_BIT] &
                       s_axis_tuser[ovmv_pkg::USER_WR_BIT];

  // The slave side only stalls when a byte is already waiting on the master side.
  `ASSERT_PROP(a_stall_needs_output, clk_i, rst_ni, !s_axis_tready |-> m_axis_tvalid, "slave stalled with empty output")

  // A strobe-high beat accepted while the output is empty leaves it empty.
  `ASSERT_PROP(a_sample_no_result, clk_i, rst_ni, (sample_beat && !m_axis_tvalid) |=> !m_axis_tvalid, "byte emitted on a sample beat")

  // A stalled output beat stays valid.
  `ASSERT_PROP(a_out_hold_valid, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "output beat dropped while stalled")

  // A stalled output beat keeps its data.
  `ASSERT_PROP(a_out_hold_data, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata), "output data changed while stalled")

endmodule

bind oversampled_write_majority_vote_top ovmv_checker u_ovmv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
